// ===== rtl/sgdm_pkg.sv =====
// Shared types, constants and saturating arithmetic for the SGD momentum update block.
package sgdm_pkg;

    // Fixed point format of weights, gradients and velocities.
    localparam int DATA_BITS        = 32;
    localparam int FRAC_BITS        = 24;
    localparam int PROD_BITS        = 2 * DATA_BITS;
    localparam int COEF_BITS        = 31;
    localparam int INDEX_BITS       = 12;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int NUM_ELEMENTS_DEF = 4096;

    typedef logic signed [DATA_BITS-1:0] t_data;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic [COEF_BITS-1:0]        t_coef;

    localparam t_data DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam t_coef LR_RESET = COEF_BITS'(167772);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_MOMENTUM_COEF = 2'd1,
        CFG_DECAY_COEF    = 2'd2,
        CFG_NESTEROV_ON   = 2'd3
    } t_cfg_reg;

    // A saturated value together with its clip flag.
    typedef struct packed {
        logic  clip;
        t_data val;
    } t_sat;

    // One result beat.
    typedef struct packed {
        logic  saturated;
        t_data weight;
    } t_result;

    // Signed value times unsigned coefficient, full width.
    function automatic t_prod mul_coef(input t_data a, input t_coef c);
        t_prod ae;
        t_prod ce;
        ae = t_prod'(a);
        ce = t_prod'({1'b0, c});
        return ae * ce;
    endfunction

    // Floor shift of a product by the fraction width, then clip to the data range.
    function automatic t_sat sat_shift(input t_prod p);
        t_prod sh;
        t_sat  r;
        sh = p >>> FRAC_BITS;
        if ((~|sh[PROD_BITS-1:DATA_BITS-1]) || (&sh[PROD_BITS-1:DATA_BITS-1])) begin
            r.clip = 1'b0;
            r.val  = sh[DATA_BITS-1:0];
        end else begin
            r.clip = 1'b1;
            r.val  = sh[PROD_BITS-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

    // Saturating sum.
    function automatic t_sat sat_add(input t_data a, input t_data b);
        logic [DATA_BITS:0] s;
        t_sat               r;
        s = {a[DATA_BITS-1], a} + {b[DATA_BITS-1], b};
        if (s[DATA_BITS] != s[DATA_BITS-1]) begin
            r.clip = 1'b1;
            r.val  = s[DATA_BITS] ? DATA_MIN : DATA_MAX;
        end else begin
            r.clip = 1'b0;
            r.val  = s[DATA_BITS-1:0];
        end
        return r;
    endfunction

    // Saturating difference.
    function automatic t_sat sat_sub(input t_data a, input t_data b);
        logic [DATA_BITS:0] s;
        t_sat               r;
        s = {a[DATA_BITS-1], a} - {b[DATA_BITS-1], b};
        if (s[DATA_BITS] != s[DATA_BITS-1]) begin
            r.clip = 1'b1;
            r.val  = s[DATA_BITS] ? DATA_MIN : DATA_MAX;
        end else begin
            r.clip = 1'b0;
            r.val  = s[DATA_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/sgdm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port returns the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sgdm_skid.sv =====
// Output register with one skid entry between the pipeline and the result channel.
module sgdm_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sgdm_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output sgdm_pkg::t_result o_data,
    output logic             o_full
);

    logic              r_out_valid;
    sgdm_pkg::t_result r_out_data;
    logic              r_skid_valid;
    sgdm_pkg::t_result r_skid_data;
    logic              w_slot_free;

    // The output slot is free when empty or when its beat is taken this cycle.
    assign w_slot_free = !r_out_valid || !i_stall;

    // Valid flags of the two entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_slot_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_full  = r_skid_valid;

endmodule

// ===== rtl/sgd_momentum_update_top.sv =====
// Top level of the SGD weight update with momentum, Nesterov step and weight decay.
//
// One weight element enters per cycle unless stalled, and its updated weight leaves
// after stages A to G and the output slot; a same-index stream keeps that rate because
// the new velocity is forwarded from the update adder straight into the momentum
// multiplier of the following element, and that loop sets the clock. When the result
// channel stalls, one further beat is held in a skid entry before the input stalls.
// After reset the velocity memory is cleared one entry per cycle while the input stalls;
// configuration writes are taken at any time. Element indexes wrap modulo NUM_ELEMENTS.
module sgd_momentum_update_top #(
    parameter int NUM_ELEMENTS = sgdm_pkg::NUM_ELEMENTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input beats.
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [sgdm_pkg::INDEX_BITS-1:0]        i_elem_index,
    input  logic signed [sgdm_pkg::DATA_BITS-1:0]  i_weight_in,
    input  logic signed [sgdm_pkg::DATA_BITS-1:0]  i_gradient_in,
    // Result beats.
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [sgdm_pkg::DATA_BITS-1:0]  o_weight_out,
    output logic                                   o_saturated,
    // Configuration writes.
    input  logic                                   i_cfg_wen,
    input  logic [sgdm_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [sgdm_pkg::COEF_BITS-1:0]         i_cfg_data
);

    localparam int AW      = NUM_ELEMENTS > 1 ? $clog2(NUM_ELEMENTS) : 1;
    localparam int NUMW    = $clog2(NUM_ELEMENTS + 1);
    localparam int IDXW    = sgdm_pkg::INDEX_BITS;
    localparam int RECIP_W = 34;
    localparam int QPW     = IDXW + RECIP_W;
    localparam int RPW     = IDXW + NUMW;
    // Rounded-up reciprocal; exact quotient for every index value.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / NUM_ELEMENTS + 64'd1);

    // Configuration registers.
    sgdm_pkg::t_coef r_lr;
    sgdm_pkg::t_coef r_mom;
    sgdm_pkg::t_coef r_dec;
    logic            r_nest;
    logic            w_mom_on;

    // Clearing pass.
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Pipeline control.
    logic w_en;
    logic w_in_accept;
    logic w_skid_full;

    // Stage A: index quotient and decay product.
    logic                  r_a_valid;
    logic [IDXW-1:0]       r_a_idx;
    logic [IDXW-1:0]       r_a_q;
    sgdm_pkg::t_data       r_a_w;
    sgdm_pkg::t_data       r_a_g;
    sgdm_pkg::t_prod       r_a_pwd;
    logic [QPW-1:0]        w_qprod;
    logic [RPW-1:0]        w_rem;
    logic [AW-1:0]         w_a_addr;
    sgdm_pkg::t_sat        w_a_dec;
    sgdm_pkg::t_sat        w_a_gd;

    // Stage B: velocity read and momentum product.
    logic                  r_b_valid;
    logic [AW-1:0]         r_b_addr;
    sgdm_pkg::t_data       r_b_w;
    sgdm_pkg::t_data       r_b_gd;
    logic                  r_b_clip;
    sgdm_pkg::t_data       w_ram_rdata;
    sgdm_pkg::t_data       w_b_vold;

    // Stage C: velocity update and write back.
    logic                  r_c_valid;
    logic [AW-1:0]         r_c_addr;
    sgdm_pkg::t_data       r_c_w;
    sgdm_pkg::t_data       r_c_gd;
    logic                  r_c_clip;
    sgdm_pkg::t_prod       r_c_pvm;
    sgdm_pkg::t_sat        w_c_mv;
    sgdm_pkg::t_sat        w_c_vnew;
    logic                  w_pipe_we;

    // Last velocity written, for the read that was in flight at the time.
    logic                  r_lw_valid;
    logic [AW-1:0]         r_lw_addr;
    sgdm_pkg::t_data       r_lw_data;

    // RAM write port.
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    sgdm_pkg::t_data       w_ram_wdata;

    // Stage D: look-ahead product.
    logic                  r_d_valid;
    sgdm_pkg::t_data       r_d_w;
    sgdm_pkg::t_data       r_d_gd;
    sgdm_pkg::t_data       r_d_v;
    logic                  r_d_clip;

    // Stage E: step selection.
    logic                  r_e_valid;
    sgdm_pkg::t_data       r_e_w;
    sgdm_pkg::t_data       r_e_gd;
    sgdm_pkg::t_data       r_e_v;
    sgdm_pkg::t_prod       r_e_pvn;
    logic                  r_e_clip;
    sgdm_pkg::t_sat        w_e_mv;
    sgdm_pkg::t_sat        w_e_ahead;
    sgdm_pkg::t_data       w_e_step;
    logic                  w_e_clip;

    // Stage F: rate product.
    logic                  r_f_valid;
    sgdm_pkg::t_data       r_f_w;
    sgdm_pkg::t_data       r_f_s;
    logic                  r_f_clip;

    // Stage G: final difference.
    logic                  r_g_valid;
    sgdm_pkg::t_data       r_g_w;
    sgdm_pkg::t_prod       r_g_plr;
    logic                  r_g_clip;
    sgdm_pkg::t_sat        w_g_rs;
    sgdm_pkg::t_sat        w_g_out;
    sgdm_pkg::t_result     w_g_result;
    sgdm_pkg::t_result     w_out_data;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= sgdm_pkg::LR_RESET;
            r_mom  <= '0;
            r_dec  <= '0;
            r_nest <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (sgdm_pkg::t_cfg_reg'(i_cfg_index))
                sgdm_pkg::CFG_LEARNING_RATE: r_lr   <= i_cfg_data;
                sgdm_pkg::CFG_MOMENTUM_COEF: r_mom  <= i_cfg_data;
                sgdm_pkg::CFG_DECAY_COEF:    r_dec  <= i_cfg_data;
                sgdm_pkg::CFG_NESTEROV_ON:   r_nest <= i_cfg_data[0];
            endcase
        end
    end

    assign w_mom_on = |r_mom;

    // Clearing pass over the velocity memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(NUM_ELEMENTS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // The whole pipeline moves together unless the skid entry is occupied.
    assign w_en        = !w_skid_full;
    assign o_stall     = r_clearing || !w_en;
    assign w_in_accept = i_valid && !o_stall;

    // Index quotient by the element count, taken from the input port.
    assign w_qprod = QPW'(i_elem_index) * QPW'(RECIP);

    // Stage A logic: remainder gives the memory address; decay term joins the gradient.
    assign w_rem    = RPW'(r_a_idx) - RPW'(r_a_q) * RPW'(NUM_ELEMENTS);
    assign w_a_addr = w_rem[AW-1:0];
    assign w_a_dec  = sgdm_pkg::sat_shift(r_a_pwd);
    assign w_a_gd   = sgdm_pkg::sat_add(r_a_g, w_a_dec.val);

    // Stage B logic: newest velocity for this address, youngest writer first.
    always_comb begin
        priority if (r_c_valid && w_mom_on && (r_c_addr == r_b_addr)) begin
            w_b_vold = w_c_vnew.val;
        end else if (r_lw_valid && (r_lw_addr == r_b_addr)) begin
            w_b_vold = r_lw_data;
        end else begin
            w_b_vold = w_ram_rdata;
        end
    end

    // Stage C logic: new velocity, written back only while momentum is on.
    assign w_c_mv    = sgdm_pkg::sat_shift(r_c_pvm);
    assign w_c_vnew  = sgdm_pkg::sat_add(w_c_mv.val, r_c_gd);
    assign w_pipe_we = w_en && r_c_valid && w_mom_on;

    // The clearing pass owns the write port while it runs.
    assign w_ram_we    = r_clearing || w_pipe_we;
    assign w_ram_waddr = r_clearing ? r_clr_addr : r_c_addr;
    assign w_ram_wdata = r_clearing ? sgdm_pkg::t_data'(0) : w_c_vnew.val;

    sgdm_ram #(
        .WIDTH (sgdm_pkg::DATA_BITS),
        .DEPTH (NUM_ELEMENTS)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_en),
        .i_raddr (w_a_addr),
        .o_rdata (w_ram_rdata)
    );

    // Stage E logic: Nesterov look-ahead or the plain velocity.
    assign w_e_mv    = sgdm_pkg::sat_shift(r_e_pvn);
    assign w_e_ahead = sgdm_pkg::sat_add(r_e_gd, w_e_mv.val);
    always_comb begin
        if (r_nest) begin
            w_e_step = w_e_ahead.val;
            w_e_clip = r_e_clip || w_e_mv.clip || w_e_ahead.clip;
        end else begin
            w_e_step = r_e_v;
            w_e_clip = r_e_clip;
        end
    end

    // Stage G logic: weight minus scaled step.
    assign w_g_rs  = sgdm_pkg::sat_shift(r_g_plr);
    assign w_g_out = sgdm_pkg::sat_sub(r_g_w, w_g_rs.val);
    assign w_g_result.weight    = w_g_out.val;
    assign w_g_result.saturated = r_g_clip || w_g_rs.clip || w_g_out.clip;

    // Valid bits travelling with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
            r_e_valid  <= 1'b0;
            r_f_valid  <= 1'b0;
            r_g_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid  <= w_in_accept;
            r_b_valid  <= r_a_valid;
            r_c_valid  <= r_b_valid;
            r_d_valid  <= r_c_valid;
            r_e_valid  <= r_d_valid;
            r_f_valid  <= r_e_valid;
            r_g_valid  <= r_f_valid;
            r_lw_valid <= r_c_valid && w_mom_on;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_idx   <= i_elem_index;
            r_a_q     <= w_qprod[32 +: IDXW];
            r_a_w     <= i_weight_in;
            r_a_g     <= i_gradient_in;
            r_a_pwd   <= sgdm_pkg::mul_coef(i_weight_in, r_dec);

            r_b_addr  <= w_a_addr;
            r_b_w     <= r_a_w;
            r_b_gd    <= w_a_gd.val;
            r_b_clip  <= w_a_dec.clip || w_a_gd.clip;

            r_c_addr  <= r_b_addr;
            r_c_w     <= r_b_w;
            r_c_gd    <= r_b_gd;
            r_c_clip  <= r_b_clip;
            r_c_pvm   <= sgdm_pkg::mul_coef(w_b_vold, r_mom);

            r_lw_addr <= r_c_addr;
            r_lw_data <= w_c_vnew.val;

            r_d_w     <= r_c_w;
            r_d_gd    <= r_c_gd;
            r_d_v     <= w_c_vnew.val;
            r_d_clip  <= r_c_clip || w_c_mv.clip || w_c_vnew.clip;

            r_e_w     <= r_d_w;
            r_e_gd    <= r_d_gd;
            r_e_v     <= r_d_v;
            r_e_pvn   <= sgdm_pkg::mul_coef(r_d_v, r_mom);
            r_e_clip  <= r_d_clip;

            r_f_w     <= r_e_w;
            r_f_s     <= w_e_step;
            r_f_clip  <= w_e_clip;

            r_g_w     <= r_f_w;
            r_g_plr   <= sgdm_pkg::mul_coef(r_f_s, r_lr);
            r_g_clip  <= r_f_clip;
        end
    end

    sgdm_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_g_valid && w_en),
        .i_data  (w_g_result),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_out_data),
        .o_full  (w_skid_full)
    );

    assign o_weight_out = w_out_data.weight;
    assign o_saturated  = w_out_data.saturated;

    // No element is in stages A to C while the clearing pass runs.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(r_a_valid || r_b_valid || r_c_valid))
        else $error("element in flight during velocity clearing");

    // Velocities are never written with momentum off.
    a_no_write_mom_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mom_on |-> !w_pipe_we)
        else $error("velocity written with momentum off");

    // A write back is recorded for the read that was in flight alongside it.
    a_last_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pipe_we |=> (r_lw_valid && (r_lw_addr == $past(r_c_addr))))
        else $error("last write record lost");

    // The skid entry fills only behind a stalled result.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_skid_full) |-> $past(o_valid && i_stall))
        else $error("skid entry filled without a stalled result");

endmodule
